/* src/greedy_graph_coloring_assert.svh */
`ifndef GREEDY_GRAPH_COLORING_ASSERT_SVH
`define GREEDY_GRAPH_COLORING_ASSERT_SVH

// Same-cycle implication checked on every clock edge outside reset.
`define GGC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define GGC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gg_pkg.sv */
package gg_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int VERT_W       = 6;
  localparam int COLOR_W      = 6;
  localparam int COUNT_W      = 7;
  localparam int ROW_W        = 64;

  typedef struct packed {
    logic [ROW_W-1:0] neighbor_mask;
    logic             last_vertex;
  } in_t;

  typedef struct packed {
    logic [VERT_W-1:0]  vertex_index;
    logic [COLOR_W-1:0] vertex_color;
    logic               last_result;
    logic [COUNT_W-1:0] color_count;
  } out_t;

endpackage

/* src/gg_ram.sv */
module gg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/greedy_graph_coloring.sv */
// Rows that are not last are taken one per cycle and produce no result.
// After the last row a load state lets the row memory settle; then each vertex
// takes a row read, a color read for every held row, free-color probes upward
// from color 0 until one is free (the top color if none is) and an output state.
// The input is stalled for the whole pass, and output stalls add to it.
// Synchronous reset clears the graph state and sets color_order to 1.
module greedy_graph_coloring (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  gg_pkg::in_t   in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gg_pkg::out_t  out_data
);
  import gg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_ROW  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_PICK = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic color_order;
  logic [COUNT_W-1:0] rows_loaded, rows_loaded_next;
  logic [COLOR_W-1:0] highest, highest_next;
  logic [ROW_W-1:0] colored, colored_next;
  logic [ROW_W-1:0] nbrs, nbrs_next;
  logic [ROW_W-1:0] used, used_next;
  logic [VERT_W-1:0] k, k_next;
  logic [VERT_W-1:0] v, v_next;
  logic [VERT_W-1:0] j, j_next;
  logic [COLOR_W-1:0] c, c_next;
  logic out_valid_next;
  out_t out_data_next;

  logic adj_we, col_we;
  logic [ROW_W-1:0] adj_rdata;
  logic [COLOR_W-1:0] col_rdata;
  logic [VERT_W-1:0] n_m1, start_last, k_inc;
  logic [COLOR_W-1:0] new_high;
  logic last_k;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  assign n_m1   = VERT_W'(rows_loaded - COUNT_W'(1));
  assign last_k = (k == n_m1);
  assign k_inc  = k + VERT_W'(1);
  // The last row is stored in this same cycle unless the graph is full.
  assign start_last = (rows_loaded < COUNT_W'(MAX_VERTICES)) ? rows_loaded[VERT_W-1:0] : n_m1;
  assign new_high   = (c > highest) ? c : highest;

  gg_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (rows_loaded[VERT_W-1:0]),
    .wdata (in_data.neighbor_mask),
    .raddr (v_next),
    .rdata (adj_rdata)
  );

  gg_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_VERTICES)) u_color_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (v),
    .wdata (c),
    .raddr (j_next),
    .rdata (col_rdata)
  );

  always_comb begin
    state_next       = state;
    rows_loaded_next = rows_loaded;
    highest_next     = highest;
    colored_next     = colored;
    nbrs_next        = nbrs;
    used_next        = used;
    k_next           = k;
    v_next           = v;
    j_next           = j;
    c_next           = c;
    out_valid_next   = out_valid;
    out_data_next    = out_data;
    adj_we           = 1'b0;
    col_we           = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (rows_loaded < COUNT_W'(MAX_VERTICES)) begin
            adj_we           = 1'b1;
            rows_loaded_next = rows_loaded + COUNT_W'(1);
          end
          if (in_data.last_vertex) begin
            k_next     = '0;
            v_next     = color_order ? '0 : start_last;
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // The first row read may have met the write of the last row on the
        // same edge, so it is issued again once that write has landed.
        state_next = ST_ROW;
      end
      ST_ROW: begin
        // Only vertices colored earlier in this pass count; the vertex
        // itself is not colored yet, so its diagonal bit drops out too.
        nbrs_next  = adj_rdata & colored;
        used_next  = '0;
        j_next     = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (nbrs[j]) begin
          used_next = used | (ROW_W'(1) << col_rdata);
        end
        if (j == n_m1) begin
          c_next     = '0;
          state_next = ST_PICK;
        end else begin
          j_next = j + VERT_W'(1);
        end
      end
      ST_PICK: begin
        if (!used[c] || c == '1) begin
          col_we        = 1'b1;
          colored_next  = colored | (ROW_W'(1) << v);
          highest_next  = new_high;
          out_valid_next = 1'b1;
          out_data_next.vertex_index = v;
          out_data_next.vertex_color = c;
          out_data_next.last_result  = last_k;
          out_data_next.color_count  = last_k ? (COUNT_W'(new_high) + COUNT_W'(1)) : '0;
          state_next    = ST_EMIT;
        end else begin
          c_next = c + COLOR_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          out_valid_next = 1'b0;
          if (last_k) begin
            colored_next     = '0;
            rows_loaded_next = '0;
            highest_next     = '0;
            state_next       = ST_IDLE;
          end else begin
            k_next     = k_inc;
            v_next     = color_order ? k_inc : (n_m1 - k_inc);
            state_next = ST_ROW;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      color_order <= 1'b1;
      rows_loaded <= '0;
      highest     <= '0;
      colored     <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      rows_loaded <= rows_loaded_next;
      highest     <= highest_next;
      colored     <= colored_next;
      out_valid   <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        color_order <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    nbrs     <= nbrs_next;
    used     <= used_next;
    k        <= k_next;
    v        <= v_next;
    j        <= j_next;
    c        <= c_next;
    out_data <= out_data_next;
  end

endmodule

/* src/gg_checker.sv */
`include "greedy_graph_coloring_assert.svh"

module gg_checker (
  input logic         clk,
  input logic         rst,
  input logic         cfg_valid,
  input logic         cfg_ready,
  input logic         cfg_data,
  input logic         in_valid,
  input logic         in_stall,
  input gg_pkg::in_t  in_data,
  input logic         out_valid,
  input logic         out_stall,
  input gg_pkg::out_t out_data
);
  import gg_pkg::*;

  // A stalled result holds its payload.
  `GGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // No new request is taken while a result is pending.
  `GGC_ASSERT_IMPLY(a_busy_emit, out_valid, in_stall, "input accepted with a result pending")

  // A row that is not last never produces a result.
  `GGC_ASSERT_NEXT(a_row_silent, in_valid && !in_stall && !in_data.last_vertex, !out_valid, "result after a non-last row")

  // The color count is zero except on the final result, where it exceeds that color.
  `GGC_ASSERT_IMPLY(a_count_mid, out_valid && !out_data.last_result, out_data.color_count == '0, "nonzero color count before the final result")
  `GGC_ASSERT_IMPLY(a_count_last, out_valid && out_data.last_result, out_data.color_count > COUNT_W'(out_data.vertex_color), "color count not above final color")

endmodule

bind greedy_graph_coloring gg_checker u_checker (.*);

/* test/tb_greedy_graph_coloring.sv */
module tb_greedy_graph_coloring;
  import gg_pkg::*;

  localparam int DIRECTED_ROWS  = 24;
  localparam int RANDOM_ROWS    = 136;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 200;
  localparam int HOLD_OFF       = 2000;
  localparam int RUN_LIMIT      = 3000000;

  typedef struct {
    bit          order;
    logic [63:0] mask;
    bit          last;
    bit          typed;
    out_t        want;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic hold_off_start = 1'b0;
  bit   calm;
  int   mismatches;

  // Predictor state: the graph being loaded and the coloring order.
  logic [63:0] adj_rows [64];
  logic [5:0]  color_of [64];
  logic [63:0] colored_set;
  int          rows_held;
  int          highest_color;
  bit          order_forward;

  out_t fresh_colors [$];
  out_t colors_due [$];

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{1'b1, '1, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b1, 7'd1}},
    '{1'b1, '0, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b1, 7'd1}},
    '{1'b1, 64'h2, 1'b0, 1'b0, '0},
    '{1'b1, 64'h1, 1'b1, 1'b0, '0},
    '{1'b1, 64'h0, 1'b0, 1'b0, '0},
    '{1'b1, 64'h1, 1'b1, 1'b0, '0},
    '{1'b1, 64'h2, 1'b0, 1'b0, '0},
    '{1'b1, 64'h0, 1'b1, 1'b0, '0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 1'b0, '0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 1'b0, '0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFF8, 1'b1, 1'b0, '0},
    '{1'b1, 64'h6, 1'b0, 1'b0, '0},
    '{1'b1, 64'h5, 1'b0, 1'b0, '0},
    '{1'b1, 64'h3, 1'b1, 1'b0, '0},
    '{1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
    '{1'b1, 64'h5555_5555_5555_5555, 1'b1, 1'b0, '0},
    '{1'b0, 64'h2, 1'b0, 1'b0, '0},
    '{1'b0, 64'h5, 1'b0, 1'b0, '0},
    '{1'b0, 64'hA, 1'b0, 1'b0, '0},
    '{1'b0, 64'h4, 1'b1, 1'b0, '0},
    '{1'b0, 64'h6, 1'b0, 1'b0, '0},
    '{1'b0, 64'h5, 1'b0, 1'b0, '0},
    '{1'b0, 64'h3, 1'b1, 1'b0, '0},
    '{1'b0, 64'h8000_0000_0000_0001, 1'b1, 1'b1, '{6'd0, 6'd0, 1'b1, 7'd1}}
  };

  greedy_graph_coloring u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] random_row();
    logic [63:0] a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      default: return a;
    endcase
  endfunction

  // Stores one adjacency row; on the last row colors the whole graph first-fit
  // and leaves the per-vertex results in fresh_colors.
  task automatic color_graph(input in_t req);
    logic [63:0] present, nbrs, used;
    int n, k, v, c, j;
    out_t res;
    if (rows_held < MAX_VERTICES) begin
      adj_rows[6'(rows_held)] = req.neighbor_mask;
      rows_held++;
    end
    if (!req.last_vertex) return;
    n = rows_held;
    present = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    for (k = 0; k < n; k++) begin
      v = order_forward ? k : n - 1 - k;
      nbrs = adj_rows[v[5:0]] & present & colored_set;
      nbrs[v[5:0]] = 1'b0;
      used = '0;
      for (j = 0; j < 64; j++) begin
        if (nbrs[j[5:0]]) used[color_of[j[5:0]]] = 1'b1;
      end
      c = 0;
      while (c < 63 && used[c[5:0]]) c++;
      color_of[v[5:0]] = c[5:0];
      colored_set[v[5:0]] = 1'b1;
      if (c > highest_color) highest_color = c;
      res.vertex_index = v[5:0];
      res.vertex_color = c[5:0];
      res.last_result  = (k == n - 1);
      res.color_count  = (k == n - 1) ? 7'(highest_color + 1) : 7'd0;
      fresh_colors.push_back(res);
    end
    colored_set   = '0;
    rows_held     = 0;
    highest_color = 0;
  endtask

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_row(input in_t req, input bit typed = 1'b0, input out_t want = '0);
    int gap;
    gap = calm ? 0 : idle_cycles();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    color_graph(req);
    if (typed) begin
      colors_due.push_back(want);
    end else begin
      foreach (fresh_colors[i]) colors_due.push_back(fresh_colors[i]);
    end
    fresh_colors.delete();
  endtask

  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (colors_due.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_order(input bit value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    order_forward = value;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s: expected %0d, got %0d", what, want, got);
  endtask

  always @(posedge clk) begin : check_results
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (colors_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no pending request: index %0d color %0d",
                   out_data.vertex_index, out_data.vertex_color);
      end else begin
        want = colors_due.pop_front();
        if (out_data.vertex_index !== want.vertex_index)
          report_mismatch("vertex_index", 64'(want.vertex_index),
                          64'(out_data.vertex_index));
        if (out_data.vertex_color !== want.vertex_color)
          report_mismatch("vertex_color", 64'(want.vertex_color),
                          64'(out_data.vertex_color));
        if (out_data.last_result !== want.last_result)
          report_mismatch("last_result", 64'(want.last_result),
                          64'(out_data.last_result));
        if (out_data.color_count !== want.color_count)
          report_mismatch("color_count", 64'(want.color_count),
                          64'(out_data.color_count));
      end
    end
  end

  // Receiver side. One long hold-off keeps a result pending so the block stalls its input.
  initial begin : stall_gen
    int run;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_start && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        run = HOLD_OFF;
      end else if ($urandom_range(0, 99) < 30) begin
        out_stall <= 1'b1;
        run = idle_cycles() + 1;
      end else begin
        out_stall <= 1'b0;
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
      end
      repeat (run) @(posedge clk);
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    in_t req;
    int  g, k, size, sent;
    bit  complete;
    colored_set   = '0;
    rows_held     = 0;
    highest_color = 0;
    order_forward = 1'b1;
    mismatches    = 0;
    calm          = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].order != order_forward) begin
        settle(SETTLE_CYCLES);
        write_order(directed_rows[i].order);
      end
      req.neighbor_mask = directed_rows[i].mask;
      req.last_vertex   = directed_rows[i].last;
      send_row(req, directed_rows[i].typed, directed_rows[i].want);
    end

    hold_off_start <= 1'b1;
    sent = 0;
    for (g = 0; sent < RANDOM_ROWS; g++) begin
      // The complete graph needs every color; the oversized one overflows the row store.
      if (g == 2 || g == 5 || (g > 0 && $urandom_range(0, 3) == 0)) begin
        settle(SETTLE_CYCLES);
        write_order(g == 2 ? 1'b1 : (g == 5 ? 1'b0 : 1'($urandom_range(0, 1))));
      end
      calm     = ($urandom_range(0, 3) == 0);
      complete = (g == 2);
      if (g == 2) size = MAX_VERTICES;
      else if (g == 5) size = MAX_VERTICES + 3;
      else size = $urandom_range(1, 8);
      for (k = 0; k < size; k++) begin
        req.neighbor_mask = complete ? '1 : random_row();
        req.last_vertex   = (k == size - 1);
        send_row(req);
        sent++;
      end
    end

    settle(TAIL_CYCLES);
    if (mismatches == 0 && colors_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
